[rtl/core/hrwl_pkg.sv]
// Package for the hex record word loader: result kinds, result and push structs, sizes.
// Depends on nothing; used by hrwl_parser, hrwl_result_queue and the top level.
package hrwl_pkg;

    localparam int unsigned PROG_WORDS_DEFAULT = 8192;
    localparam int unsigned ADDR_W             = 13;
    localparam int unsigned DATA_W             = 16;
    localparam int unsigned QUEUE_DEPTH        = 4;
    localparam int unsigned QUEUE_PTR_W        = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_LVL_W        = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [ADDR_W-1:0]   word_address;
        logic [DATA_W-1:0]   word_data;
        logic                record_end;
    } result_t;

    // Up to two results come out of one character: slot0 first, then slot1.
    typedef struct packed {
        logic [1:0] count;
        result_t    slot0;
        result_t    slot1;
    } push_t;

endpackage

[rtl/core/hrwl_parser.sv]
// Record parser: per-line state registers and the one-character decode step.
// Depends on hrwl_pkg; produces a push_t with zero to two results per accepted word.
module hrwl_parser #(
    parameter int unsigned PROG_WORDS = hrwl_pkg::PROG_WORDS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      char_code,
    input  logic            line_end,
    output hrwl_pkg::push_t push
);

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_F     = 8'h46;

    typedef enum logic [5:0] {
        PH_COLON = 6'b000001,
        PH_COUNT = 6'b000010,
        PH_ADDR  = 6'b000100,
        PH_TYPE  = 6'b001000,
        PH_DATA  = 6'b010000,
        PH_SKIP  = 6'b100000
    } phase_t;

    phase_t       phase_reg,  phase_next;
    logic [1:0]   idx_reg,    idx_next;
    logic [6:0]   words_reg,  words_next;
    logic [15:0]  addr_reg,   addr_next;
    logic [15:0]  accum_reg,  accum_next;

    logic                 digit_ok;
    logic [3:0]           nib;
    logic [15:0]          addr_shift;
    logic [15:0]          word;
    logic                 last;
    logic                 in_range;
    logic                 do_close;
    hrwl_pkg::kind_t      close_kind;
    logic                 prim_valid;
    hrwl_pkg::result_t    prim;
    hrwl_pkg::result_t    rej;
    logic                 rej_valid;

    always_comb
    begin
        digit_ok = 1'b0;
        nib      = 4'd0;
        if (char_code inside {[CHAR_ZERO:CHAR_NINE]})
        begin
            digit_ok = 1'b1;
            nib      = 4'(char_code - CHAR_ZERO);
        end
        else if (char_code inside {[CHAR_A:CHAR_F]})
        begin
            digit_ok = 1'b1;
            nib      = 4'(char_code - CHAR_A + 8'd10);
        end
    end

    assign addr_shift = {addr_reg[11:0], nib};
    assign in_range   = ({1'b0, addr_reg} < 17'(PROG_WORDS));
    assign last       = (words_reg <= 7'd1);

    always_comb
    begin
        case (idx_reg)
            2'd0:    word = accum_reg | {8'd0, nib, 4'd0};
            2'd1:    word = accum_reg | {12'd0, nib};
            2'd2:    word = accum_reg | {nib, 12'd0};
            default: word = accum_reg | {4'd0, nib, 8'd0};
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        words_next = words_reg;
        addr_next  = addr_reg;
        accum_next = accum_reg;
        do_close   = 1'b0;
        close_kind = hrwl_pkg::KIND_REJECT;
        prim_valid = 1'b0;
        prim       = '0;

        case (phase_reg)
            PH_COLON:
            begin
                if (char_code == CHAR_COLON)
                begin
                    phase_next = PH_COUNT;
                    idx_next   = 2'd0;
                    accum_next = 16'd0;
                end
                else
                begin
                    do_close = 1'b1;
                end
            end
            PH_COUNT:
            begin
                if (!digit_ok)
                begin
                    do_close = 1'b1;
                end
                else
                begin
                    accum_next = {8'd0, accum_reg[3:0], nib};
                    if (idx_reg != 2'd0)
                    begin
                        phase_next = PH_ADDR;
                        idx_next   = 2'd0;
                        addr_next  = 16'd0;
                    end
                    else
                    begin
                        idx_next = 2'd1;
                    end
                end
            end
            PH_ADDR:
            begin
                if (!digit_ok)
                begin
                    do_close = 1'b1;
                end
                else if (idx_reg == 2'd3)
                begin
                    // count and address must both be even
                    if (accum_reg[0] || addr_shift[0])
                    begin
                        do_close = 1'b1;
                    end
                    else
                    begin
                        words_next = accum_reg[7:1];
                        addr_next  = {1'b0, addr_shift[15:1]};
                        accum_next = 16'd0;
                        idx_next   = 2'd0;
                        phase_next = PH_TYPE;
                    end
                end
                else
                begin
                    addr_next = addr_shift;
                    idx_next  = idx_reg + 2'd1;
                end
            end
            PH_TYPE:
            begin
                if (char_code != CHAR_ZERO)
                begin
                    do_close   = 1'b1;
                    close_kind = hrwl_pkg::KIND_ACCEPT;
                end
                else if (idx_reg == 2'd0)
                begin
                    idx_next = 2'd1;
                end
                else if (words_reg == 7'd0)
                begin
                    do_close   = 1'b1;
                    close_kind = hrwl_pkg::KIND_ACCEPT;
                end
                else
                begin
                    phase_next = PH_DATA;
                    idx_next   = 2'd0;
                    accum_next = 16'd0;
                end
            end
            PH_DATA:
            begin
                if (!digit_ok)
                begin
                    do_close = 1'b1;
                end
                else if (idx_reg == 2'd3)
                begin
                    if (in_range)
                    begin
                        prim_valid        = 1'b1;
                        prim.kind         = hrwl_pkg::KIND_WRITE;
                        prim.word_address = addr_reg[hrwl_pkg::ADDR_W-1:0];
                        prim.word_data    = word;
                        prim.record_end   = last;
                    end
                    else if (last)
                    begin
                        prim_valid      = 1'b1;
                        prim.kind       = hrwl_pkg::KIND_ACCEPT;
                        prim.record_end = 1'b1;
                    end
                    addr_next  = addr_reg + 16'd1;
                    words_next = words_reg - 7'd1;
                    accum_next = 16'd0;
                    idx_next   = 2'd0;
                    if (last)
                    begin
                        phase_next = PH_SKIP;
                    end
                end
                else
                begin
                    accum_next = word;
                    idx_next   = idx_reg + 2'd1;
                end
            end
            PH_SKIP:
            begin
                phase_next = PH_SKIP;
            end
            default:
            begin
                phase_next = PH_COLON;
            end
        endcase

        if (do_close)
        begin
            prim_valid      = 1'b1;
            prim.kind       = close_kind;
            prim.record_end = 1'b1;
            phase_next      = PH_SKIP;
        end

        // line end: reject an open record, then back to reset values
        rej_valid = line_end && (phase_next != PH_SKIP);
        if (line_end)
        begin
            phase_next = PH_COLON;
            idx_next   = 2'd0;
            words_next = 7'd0;
            addr_next  = 16'd0;
            accum_next = 16'd0;
        end
    end

    always_comb
    begin
        rej            = '0;
        rej.kind       = hrwl_pkg::KIND_REJECT;
        rej.record_end = 1'b1;
        push.slot0     = prim_valid ? prim : rej;
        push.slot1     = rej;
        push.count     = accept ? ({1'b0, prim_valid} + {1'b0, rej_valid}) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_COLON;
            idx_reg   <= 2'd0;
            words_reg <= 7'd0;
            addr_reg  <= 16'd0;
            accum_reg <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            words_reg <= words_next;
            addr_reg  <= addr_next;
            accum_reg <= accum_next;
        end
    end

endmodule

[rtl/core/hrwl_result_queue.sv]
// Result queue: small register queue taking up to two results a cycle, giving one.
// Depends on hrwl_pkg; room stays high while two free entries remain.
module hrwl_result_queue (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  hrwl_pkg::push_t                      push,
    output logic                                 room,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output hrwl_pkg::result_t                    head,
    output logic [hrwl_pkg::QUEUE_LVL_W-1:0]     level
);

    localparam int unsigned PW = hrwl_pkg::QUEUE_PTR_W;
    localparam int unsigned LW = hrwl_pkg::QUEUE_LVL_W;

    hrwl_pkg::result_t      entry_reg [hrwl_pkg::QUEUE_DEPTH];
    logic [PW-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0]          level_reg,  level_next;
    logic                   pop;
    logic [PW-1:0]          wr_ptr_b;

    assign pop       = out_valid && out_ready;
    assign out_valid = (level_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign level     = level_reg;
    assign room      = (level_reg <= LW'(hrwl_pkg::QUEUE_DEPTH - 2));
    assign wr_ptr_b  = wr_ptr_reg + PW'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push.count);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        level_next  = level_reg + LW'(push.count) - LW'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < hrwl_pkg::QUEUE_DEPTH; i++)
        begin
            if (push.count != 2'd0 && wr_ptr_reg == PW'(i))
            begin
                entry_reg[i] <= push.slot0;
            end
            else if (push.count == 2'd2 && wr_ptr_b == PW'(i))
            begin
                entry_reg[i] <= push.slot1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

[rtl/core/hex_record_word_loader_core.sv]
// Top level of the hex record word loader: parser plus result queue.
// Depends on hrwl_pkg, hrwl_parser and hrwl_result_queue.
//
//  channel   direction  handshake                    payload
//  char      in         char_valid / char_ready      char_code[7:0], line_end
//  result    out        result_valid / result_ready  kind[1:0], word_address[12:0],
//                                                    word_data[15:0], record_end
//
// One character word is taken per cycle while char_ready is high; its results
// are written into a four-entry queue at the edge that takes the character and
// leave on the result side in order, at most one per cycle. A character yields
// zero, one or two results, so the sustained rate is one character per cycle as
// long as the results drain at least as fast as they are made. char_ready drops
// when fewer than two queue entries are free, which is what a stalled result
// side ends up throttling. rst_n clears the parser state and empties the
// queue at once; no clearing pass follows.
module hex_record_word_loader_core #(
    parameter int unsigned PROG_WORDS = hrwl_pkg::PROG_WORDS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           char_valid,
    output logic                           char_ready,
    input  logic [7:0]                     char_code,
    input  logic                           line_end,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic [1:0]                     kind,
    output logic [hrwl_pkg::ADDR_W-1:0]    word_address,
    output logic [hrwl_pkg::DATA_W-1:0]    word_data,
    output logic                           record_end
);

    logic                                  accept;
    logic                                  room;
    hrwl_pkg::push_t                       push;
    hrwl_pkg::result_t                     head;
    logic [hrwl_pkg::QUEUE_LVL_W-1:0]      level;

    // ready only depends on queue space, never on the parse phase
    assign char_ready = room;
    assign accept     = char_valid && char_ready;

    hrwl_parser #(
        .PROG_WORDS (PROG_WORDS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_code (char_code),
        .line_end  (line_end),
        .push      (push)
    );

    hrwl_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .head      (head),
        .level     (level)
    );

    assign kind         = head.kind;
    assign word_address = head.word_address;
    assign word_data    = head.word_data;
    assign record_end   = head.record_end;

    // results are only produced by an accepted character word
    a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> accept)
        else $error("results pushed without an accepted character");

    // a double result is always a non-final write followed by a line-end reject
    a_double_shape: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> (push.slot0.kind == hrwl_pkg::KIND_WRITE
                                && !push.slot0.record_end
                                && push.slot1.kind == hrwl_pkg::KIND_REJECT))
        else $error("unexpected pair of results from one character");

    // the queue never holds more than its depth
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= hrwl_pkg::QUEUE_LVL_W'(hrwl_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    // after a push, result_valid is high in the next cycle
    a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |=> result_valid)
        else $error("pushed result not presented");

endmodule

[tb/sv/tb_hex_record_word_loader_core.sv]
// Self-checking bench for hex_record_word_loader_core: HEX text in, word writes and status out.
// Depends on hrwl_pkg and the RTL only; a cycle-free parser model inside predicts all results but typed rows.
// Directed rows first, then random records (clean, cut short, corrupted, noise) under random stalls.
module tb_hex_record_word_loader_core;

    localparam int unsigned ITEM_TARGET = 1300;  // characters to send in total
    localparam int unsigned CALM_TAIL   = 150;   // last characters sent with no idling
    localparam int unsigned DRAIN_WAIT  = 10;    // cycles after the last expected word

    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [4:0] BAD_NIB    = 5'd16;

    // Parser position within one line.
    typedef enum logic [2:0] {
        PH_COLON,
        PH_COUNT,
        PH_ADDR,
        PH_TYPE,
        PH_DATA,
        PH_SKIP
    } parse_phase_t;

    // How a sent character's results are known: from the parser model or typed in the row.
    typedef enum logic {
        CHK_PRED,
        CHK_TYPED
    } row_check_t;

    typedef struct packed {
        logic [7:0]        ch;
        logic              le;
        row_check_t        chk;
        hrwl_pkg::result_t want;   // only used on typed rows, which yield exactly one word
    } text_char_t;

    localparam hrwl_pkg::result_t NO_RESULT  = '0;
    localparam hrwl_pkg::result_t REJECT_END = '{hrwl_pkg::KIND_REJECT, '0, '0, 1'b1};
    localparam hrwl_pkg::result_t ACCEPT_END = '{hrwl_pkg::KIND_ACCEPT, '0, '0, 1'b1};
    localparam hrwl_pkg::result_t TOP_WRITE  =
        '{hrwl_pkg::KIND_WRITE, 13'h1FFF, 16'hFFFF, 1'b0};

    // Directed text. Lines, in order:
    //   "X"           missing colon
    //   0x00, 0xFF    missing colon at both ends of the byte range
    //   ":G"          bad digit in the count
    //   ":0"          line ends before the record is complete
    //   ":01FFFF" Q   odd count, then an ignored character carrying the line end
    //   ":043FFE00FFFF0000"  top word written with all ones, next word past program end
    localparam int unsigned N_DIRECTED = 32;
    localparam text_char_t DIRECTED [N_DIRECTED] = '{
        '{"X",   1'b1, CHK_TYPED, REJECT_END},
        '{8'h00, 1'b1, CHK_TYPED, REJECT_END},
        '{8'hFF, 1'b1, CHK_TYPED, REJECT_END},
        '{":",   1'b0, CHK_PRED,  NO_RESULT},
        '{"G",   1'b1, CHK_TYPED, REJECT_END},
        '{":",   1'b0, CHK_PRED,  NO_RESULT},
        '{"0",   1'b1, CHK_TYPED, REJECT_END},
        '{":",   1'b0, CHK_PRED,  NO_RESULT},
        '{"0",   1'b0, CHK_PRED,  NO_RESULT},
        '{"1",   1'b0, CHK_PRED,  NO_RESULT},
        '{"F",   1'b0, CHK_PRED,  NO_RESULT},
        '{"F",   1'b0, CHK_PRED,  NO_RESULT},
        '{"F",   1'b0, CHK_PRED,  NO_RESULT},
        '{"F",   1'b0, CHK_TYPED, REJECT_END},
        '{"Q",   1'b1, CHK_PRED,  NO_RESULT},
        '{":",   1'b0, CHK_PRED,  NO_RESULT},
        '{"0",   1'b0, CHK_PRED,  NO_RESULT},
        '{"4",   1'b0, CHK_PRED,  NO_RESULT},
        '{"3",   1'b0, CHK_PRED,  NO_RESULT},
        '{"F",   1'b0, CHK_PRED,  NO_RESULT},
        '{"F",   1'b0, CHK_PRED,  NO_RESULT},
        '{"E",   1'b0, CHK_PRED,  NO_RESULT},
        '{"0",   1'b0, CHK_PRED,  NO_RESULT},
        '{"0",   1'b0, CHK_PRED,  NO_RESULT},
        '{"F",   1'b0, CHK_PRED,  NO_RESULT},
        '{"F",   1'b0, CHK_PRED,  NO_RESULT},
        '{"F",   1'b0, CHK_PRED,  NO_RESULT},
        '{"F",   1'b0, CHK_TYPED, TOP_WRITE},
        '{"0",   1'b0, CHK_PRED,  NO_RESULT},
        '{"0",   1'b0, CHK_PRED,  NO_RESULT},
        '{"0",   1'b0, CHK_PRED,  NO_RESULT},
        '{"0",   1'b1, CHK_TYPED, ACCEPT_END}
    };

    // Characters that sit just outside the accepted digit set.
    string near_miss = "/:@G[agf ";

    logic                          clk;
    logic                          rst_n;
    logic                          char_valid;
    logic                          char_ready;
    logic [7:0]                    char_code;
    logic                          line_end;
    logic                          result_valid;
    logic                          result_ready;
    logic [1:0]                    kind;
    logic [hrwl_pkg::ADDR_W-1:0]   word_address;
    logic [hrwl_pkg::DATA_W-1:0]   word_data;
    logic                          record_end;

    // Parser model state.
    parse_phase_t        ps_phase;
    logic [1:0]          ps_digit;
    logic [6:0]          ps_words;
    logic [15:0]         ps_waddr;
    logic [15:0]         ps_accum;
    logic                ps_closed;

    hrwl_pkg::result_t   step_out [$];      // words made by the last modeled character
    hrwl_pkg::result_t   pending_words [$]; // words still owed by the block, oldest first
    logic [7:0]          line_text [$];     // random line being assembled

    int unsigned         fail_count;
    int unsigned         chars_sent;
    int unsigned         lines_sent;
    int unsigned         gap_pct;
    int unsigned         stall_pct;
    int unsigned         seen_kind [3];
    bit                  calm;

    hex_record_word_loader_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_code    (char_code),
        .line_end     (line_end),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .word_address (word_address),
        .word_data    (word_data),
        .record_end   (record_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case a handshake hangs.
    initial
    begin
        #2000000;
        $display("hex_record_word_loader_core verification failed");
        $finish;
    end

    // ---------------------------------------------------------------- parser model

    function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
        if (ch >= CH_ZERO && ch <= CH_NINE)
            return 5'(ch - CH_ZERO);
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_F)
            return 5'(ch - CH_UPPER_A + 8'd10);
        return BAD_NIB;
    endfunction

    function automatic void parse_reset();
        ps_phase  = PH_COLON;
        ps_digit  = '0;
        ps_words  = '0;
        ps_waddr  = '0;
        ps_accum  = '0;
        ps_closed = 1'b0;
    endfunction

    // Closing word of a record; the rest of the line is then skipped.
    function automatic void close_record(input hrwl_pkg::kind_t k);
        step_out.push_back('{k, '0, '0, 1'b1});
        ps_closed = 1'b1;
        ps_phase  = PH_SKIP;
    endfunction

    // Steps the model by one character and leaves its words in step_out.
    function automatic void parse_char(input logic [7:0] ch, input logic le);
        logic [4:0] nib;
        logic       last;
        nib = hex_nibble(ch);
        step_out.delete();
        case (ps_phase)
            PH_COLON:
            begin
                if (ch == CH_COLON)
                begin
                    ps_phase = PH_COUNT;
                    ps_digit = '0;
                    ps_accum = '0;
                end
                else
                    close_record(hrwl_pkg::KIND_REJECT);
            end
            PH_COUNT:
            begin
                if (nib == BAD_NIB)
                    close_record(hrwl_pkg::KIND_REJECT);
                else
                begin
                    ps_accum = {8'h00, ps_accum[3:0], nib[3:0]};
                    if (ps_digit >= 2'd1)
                    begin
                        ps_phase = PH_ADDR;
                        ps_digit = '0;
                        ps_waddr = '0;
                    end
                    else
                        ps_digit = 2'd1;
                end
            end
            PH_ADDR:
            begin
                if (nib == BAD_NIB)
                    close_record(hrwl_pkg::KIND_REJECT);
                else
                begin
                    ps_waddr = {ps_waddr[11:0], nib[3:0]};
                    if (ps_digit == 2'd3)
                    begin
                        // byte count and byte address must both be even
                        if (ps_accum[0] || ps_waddr[0])
                            close_record(hrwl_pkg::KIND_REJECT);
                        else
                        begin
                            ps_words = ps_accum[7:1];
                            ps_waddr = ps_waddr >> 1;
                            ps_accum = '0;
                            ps_digit = '0;
                            ps_phase = PH_TYPE;
                        end
                    end
                    else
                        ps_digit = ps_digit + 2'd1;
                end
            end
            PH_TYPE:
            begin
                // any character other than '0' makes a record without data
                if (ch != CH_ZERO)
                    close_record(hrwl_pkg::KIND_ACCEPT);
                else if (ps_digit == 2'd0)
                    ps_digit = 2'd1;
                else if (ps_words == '0)
                    close_record(hrwl_pkg::KIND_ACCEPT);
                else
                begin
                    ps_phase = PH_DATA;
                    ps_digit = '0;
                    ps_accum = '0;
                end
            end
            PH_DATA:
            begin
                if (nib == BAD_NIB)
                    close_record(hrwl_pkg::KIND_REJECT);
                else
                begin
                    // low byte comes first in the text
                    case (ps_digit)
                        2'd0:    ps_accum |= {8'h00, nib[3:0], 4'h0};
                        2'd1:    ps_accum |= {12'h000, nib[3:0]};
                        2'd2:    ps_accum |= {nib[3:0], 12'h000};
                        default: ps_accum |= {4'h0, nib[3:0], 8'h00};
                    endcase
                    if (ps_digit == 2'd3)
                    begin
                        last = (ps_words <= 7'd1);
                        if (32'(ps_waddr) < hrwl_pkg::PROG_WORDS_DEFAULT)
                            step_out.push_back('{hrwl_pkg::KIND_WRITE,
                                                 ps_waddr[hrwl_pkg::ADDR_W-1:0],
                                                 ps_accum, last});
                        else if (last)
                            step_out.push_back(ACCEPT_END);
                        ps_waddr = ps_waddr + 16'd1;
                        ps_words = ps_words - 7'd1;
                        ps_accum = '0;
                        ps_digit = '0;
                        if (last)
                        begin
                            ps_closed = 1'b1;
                            ps_phase  = PH_SKIP;
                        end
                    end
                    else
                        ps_digit = ps_digit + 2'd1;
                end
            end
            default:
            begin
            end
        endcase
        // an unfinished record is rejected after the character itself is handled
        if (le)
        begin
            if (!ps_closed)
                step_out.push_back(REJECT_END);
            parse_reset();
        end
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? CH_ZERO + 8'(n) : CH_UPPER_A + 8'(n) - 8'd10;
    endfunction

    function automatic void push_hex(input logic [15:0] v, input int digits);
        for (int d = digits - 1; d >= 0; d--)
            line_text.push_back(hex_char(v[d*4 +: 4]));
    endfunction

    function automatic logic [7:0] random_non_colon();
        logic [7:0] ch;
        ch = 8'($urandom_range(0, 254));
        if (ch >= CH_COLON)
            ch = ch + 8'd1;
        return ch;
    endfunction

    // Presents one character word, waits for it to be taken and books its words.
    task automatic send_char(input text_char_t c);
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            char_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        char_valid <= 1'b1;
        char_code  <= c.ch;
        line_end   <= c.le;
        do
            @(posedge clk);
        while (!char_ready);
        parse_char(c.ch, c.le);
        if (c.chk == CHK_TYPED)
            pending_words.push_back(c.want);
        else
            foreach (step_out[k])
                pending_words.push_back(step_out[k]);
        chars_sent++;
        if (c.le)
            lines_sent++;
        if (chars_sent + CALM_TAIL >= ITEM_TARGET)
            calm = 1'b1;
        @(negedge clk);
    endtask

    // Builds one random line: mostly clean records with random content, the rest cut
    // short, odd-sized or odd-addressed, corrupted, missing the colon, or plain noise.
    task automatic send_random_line();
        text_char_t  c;
        logic [7:0]  bcount;
        logic [15:0] baddr;
        logic [7:0]  rtype;
        int          words;
        int          mode;
        int          pick;
        int          pos;
        mode = $urandom_range(0, 99);
        pick = $urandom_range(0, 99);
        if (pick < 15)
            words = 0;
        else if (pick < 85)
            words = $urandom_range(1, 4);
        else if (pick < 97)
            words = $urandom_range(5, 16);
        else
            words = $urandom_range(100, 127);
        bcount = 8'(words * 2);
        // address: low memory, across the program end, top of the space, or anywhere
        case ($urandom_range(0, 3))
            0:       baddr = 16'($urandom_range(0, 63));
            1:       baddr = 16'h3FF0 + 16'($urandom_range(0, 32));
            2:       baddr = 16'hFF00 + 16'($urandom_range(0, 255));
            default: baddr = 16'($urandom);
        endcase
        baddr[0] = 1'b0;
        if (mode >= 75 && mode < 83)
        begin
            if ($urandom_range(0, 1) == 1)
                bcount[0] = 1'b1;
            else
                baddr[0] = 1'b1;
        end
        rtype = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;

        line_text.delete();
        line_text.push_back(CH_COLON);
        push_hex(16'(bcount), 2);
        push_hex(baddr, 4);
        push_hex(16'(rtype), 2);
        if (rtype == 8'h00)
        begin
            for (int w = 0; w < words; w++)
                push_hex(16'($urandom), 4);
        end
        else
            push_hex(16'($urandom), $urandom_range(0, 4));
        if ($urandom_range(0, 4) != 0)
            push_hex(16'($urandom_range(0, 255)), 2);

        if (mode >= 65 && mode < 75)
        begin
            // line ends early, possibly right on a completed word
            pos = $urandom_range(1, line_text.size() - 1);
            while (line_text.size() > pos)
                void'(line_text.pop_back());
        end
        else if (mode >= 83 && mode < 92)
        begin
            pos = $urandom_range(0, line_text.size() - 1);
            if ($urandom_range(0, 1) == 1)
                line_text[pos] = 8'($urandom_range(0, 255));
            else
                line_text[pos] = near_miss[$urandom_range(0, near_miss.len() - 1)];
        end
        else if (mode >= 92 && mode < 95)
            line_text[0] = random_non_colon();
        else if (mode >= 95)
        begin
            line_text.delete();
            repeat ($urandom_range(1, 6))
                line_text.push_back(8'($urandom_range(0, 255)));
        end

        foreach (line_text[k])
        begin
            c.ch   = line_text[k];
            c.le   = (k == line_text.size() - 1);
            c.chk  = CHK_PRED;
            c.want = NO_RESULT;
            send_char(c);
        end
    endtask

    // ---------------------------------------------------------------- result side

    // Backpressure in random bursts; the burst rate drifts over the run.
    initial
    begin
        result_ready = 1'b0;
        stall_pct    = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 63) == 0)
                stall_pct = 10 * $urandom_range(0, 5);
            if (!calm && $urandom_range(0, 99) < stall_pct)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            result_ready <= 1'b1;
        end
    end

    function automatic void field_miss(input string field, input int unsigned want,
                                       input int unsigned got);
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        fail_count++;
    endfunction

    // Every word taken on the result side must match the oldest one owed.
    always @(posedge clk)
    begin : word_check
        hrwl_pkg::result_t owed;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected word: kind %0d address 0x%0h data 0x%0h end %0b",
                       kind, word_address, word_data, record_end);
                fail_count++;
            end
            else
            begin
                owed = pending_words.pop_front();
                if (kind < 2'd3)
                    seen_kind[kind]++;
                if (kind != owed.kind)
                    field_miss("kind", owed.kind, kind);
                if (word_address != owed.word_address)
                    field_miss("word_address", owed.word_address, word_address);
                if (word_data != owed.word_data)
                    field_miss("word_data", owed.word_data, word_data);
                if (record_end != owed.record_end)
                    field_miss("record_end", owed.record_end, record_end);
            end
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial
    begin
        rst_n      = 1'b0;
        char_valid = 1'b0;
        char_code  = '0;
        line_end   = 1'b0;
        fail_count = 0;
        chars_sent = 0;
        lines_sent = 0;
        calm       = 1'b0;
        gap_pct    = 20;
        seen_kind  = '{0, 0, 0};
        parse_reset();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < N_DIRECTED; r++)
            send_char(DIRECTED[r]);

        while (chars_sent < ITEM_TARGET)
        begin
            // sender pace changes per line; zero gives long stretches back to back
            case ($urandom_range(0, 4))
                0, 1:    gap_pct = 0;
                2:       gap_pct = 10;
                3:       gap_pct = 30;
                default: gap_pct = 60;
            endcase
            send_random_line();
        end
        char_valid <= 1'b0;

        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d characters in %0d lines; checked %0d writes, %0d accepts, %0d rejects.",
                 chars_sent, lines_sent, seen_kind[hrwl_pkg::KIND_WRITE],
                 seen_kind[hrwl_pkg::KIND_ACCEPT], seen_kind[hrwl_pkg::KIND_REJECT]);
        if (fail_count == 0)
            $display("hex_record_word_loader_core verification clean");
        else
            $display("hex_record_word_loader_core verification failed");
        $finish;
    end

endmodule

[hex_record_word_loader_core.f]
rtl/core/hrwl_pkg.sv
rtl/core/hrwl_parser.sv
rtl/core/hrwl_result_queue.sv
rtl/core/hex_record_word_loader_core.sv
tb/sv/tb_hex_record_word_loader_core.sv
